// ----- design/pfse_pkg.sv -----
// ----------------------------------------------------------------------------
// pfse_pkg
// shared types, constants and helpers for the squared-error pid controller
// ----------------------------------------------------------------------------
package pfse_pkg;

  localparam int FRAC_BITS         = 16;
  localparam int ERROR_SCALE_SHIFT = 1;
  localparam int SLEW_LIMIT        = 65536;
  localparam int ALPHA_ONE         = 65536;
  localparam logic [31:0] DECAY_THRESH = 32'((((64'd1) << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [31:0] DECAY_FACTOR = 32'(((64'd9 << FRAC_BITS) + 64'd5) / 64'd10);

  localparam logic [2:0] REG_PROP    = 3'd0;
  localparam logic [2:0] REG_INT     = 3'd1;
  localparam logic [2:0] REG_DERIV   = 3'd2;
  localparam logic [2:0] REG_ALPHA   = 3'd3;
  localparam logic [2:0] REG_TARGET  = 3'd4;
  localparam logic [2:0] REG_LOW     = 3'd5;
  localparam logic [2:0] REG_HIGH    = 3'd6;
  localparam logic [2:0] REG_REVERSE = 3'd7;

  // datapath operations, one per controller step
  typedef enum logic [3:0] {
    OP_LOAD, OP_FILT_A, OP_FILT_B, OP_ERR, OP_SQ, OP_PTERM, OP_DTERM, OP_ITERM,
    OP_INTEG, OP_DRIVE
  } op_t;

  typedef struct packed {
    logic start_mul;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
  } dp_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (x < -66'sh80000000) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage

// ----- design/pfse_mul.sv -----
// ----------------------------------------------------------------------------
// pfse_mul
// 32x32 unsigned multiplier built from four 16x16 partial products over cycles
// ----------------------------------------------------------------------------
module pfse_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod,
  output logic        done
);
  logic [2:0]  step;
  logic [1:0]  idx;
  logic [15:0] pa, pb;
  logic [31:0] pp;

  assign idx = step[1:0];
  assign pa = idx[0] ? a[31:16] : a[15:0];
  assign pb = idx[1] ? b[31:16] : b[15:0];
  assign pp = pa * pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 3'd4;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= 3'd0;
        prod <= '0;
      end else if (!step[2]) begin
        prod <= prod + ({32'd0, pp} << ({5'd0, idx[0]} * 6'd16 + {5'd0, idx[1]} * 6'd16));
        step <= step + 3'd1;
        if (step == 3'd3) done <= 1'b1;
      end
    end
  end
endmodule

// ----- design/pfse_datapath.sv -----
// ----------------------------------------------------------------------------
// pfse_datapath
// state registers and arithmetic steps of the controller, one multiplier
// ----------------------------------------------------------------------------
module pfse_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pfse_pkg::dp_cmd_t   cmd,
  output pfse_pkg::dp_status_t status,
  input  logic signed [31:0]  measurement,
  input  logic [31:0]         prop_gain,
  input  logic [31:0]         int_gain_dt,
  input  logic [31:0]         deriv_gain_dt,
  input  logic [16:0]         filter_alpha,
  input  logic signed [31:0]  target,
  input  logic signed [31:0]  low_limit,
  input  logic signed [31:0]  high_limit,
  input  logic                reverse_mode,
  input  logic                clear,
  output logic signed [31:0]  drive_value,
  output logic                limit_hit
);
  import pfse_pkg::*;

  logic signed [31:0] smoothed, integ, prev, last, m, esq, pterm, dterm, itmp;
  logic signed [63:0] acc;
  logic [31:0] ma, mb;
  logic        neg;
  logic [63:0] prod;
  logic        mdone;
  logic [16:0] alpha;
  logic signed [31:0] e;
  logic [31:0] emag;
  logic [63:0] rnd;
  logic [31:0] rmag;
  logic signed [33:0] rsgn;
  logic signed [33:0] pot, pre, raw, dlt;
  logic        dec;

  assign alpha = (filter_alpha > 17'(ALPHA_ONE)) ? 17'(ALPHA_ONE) : filter_alpha;
  assign status.mul_done = mdone;

  pfse_mul u_mul (.clk(clk), .rst(rst), .start(cmd.start_mul), .a(ma), .b(mb),
    .prod(prod), .done(mdone));

  // rounded-by-magnitude product scaled back to q16.16, saturated to 32 bits
  assign rnd  = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign rmag = (rnd > 64'h7FFFFFFF) ? 32'h8000_0000 : rnd[31:0];
  assign rsgn = neg ? -$signed({2'b0, rmag}) : $signed({2'b0, rmag});
  assign e    = sat32(66'(($signed({{2{target[31]}}, target}) -
                 $signed({{2{smoothed[31]}}, smoothed})) >>> ERROR_SCALE_SHIFT));
  assign emag = e[31] ? 32'(-e) : e;
  assign pot  = 34'(sat32(66'(integ) + 66'(itmp)));
  assign pre  = 34'(pterm) + pot - 34'(dterm);
  assign dec  = integ > $signed(DECAY_THRESH) || integ < -$signed(DECAY_THRESH);
  assign raw  = (34'(pterm) + 34'(integ) - 34'(dterm) > 34'(high_limit)) ? 34'(high_limit) :
                (34'(pterm) + 34'(integ) - 34'(dterm) < 34'(low_limit)) ? 34'(low_limit) :
                34'(pterm) + 34'(integ) - 34'(dterm);
  assign dlt  = raw - 34'(prev);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_FILT_A: begin ma = m[31] ? 32'(-m) : m; mb = 32'(alpha); end
      OP_FILT_B: begin ma = last[31] ? 32'(-last) : last; mb = 32'(17'(ALPHA_ONE) - alpha); end
      OP_SQ:     begin ma = emag; mb = emag; end
      OP_PTERM:  begin ma = esq[31] ? 32'(-esq) : esq; mb = prop_gain; end
      OP_DTERM:  begin ma = dterm[31] ? 32'(-dterm) : dterm; mb = deriv_gain_dt; end
      OP_ITERM:  begin
        if (int_gain_dt != 0) begin ma = esq[31] ? 32'(-esq) : esq; mb = int_gain_dt; end
        else begin ma = integ[31] ? 32'(-integ) : integ; mb = DECAY_FACTOR; end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      smoothed <= '0;
      integ    <= '0;
      prev     <= '0;
    end else if (!cmd.start_mul && mdone) begin
      case (cmd.op)
        OP_FILT_A: acc <= m[31] ? -$signed(prod) : $signed(prod);
        OP_FILT_B: begin
          smoothed <= sat32(66'((acc + (last[31] ? -$signed(prod) : $signed(prod))
                      + 64'sd32768) >>> 16));
        end
        OP_SQ: begin
          esq <= (e > 0) ? ((rnd > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(rnd[31:0])) :
                 ((rnd > 64'h7FFFFFFF) ? -32'sh7FFFFFFF : -$signed(rnd[31:0]));
        end
        OP_PTERM: pterm <= sat32(66'(rsgn));
        OP_DTERM: dterm <= sat32(66'(rsgn));
        OP_ITERM: itmp  <= sat32(66'(rsgn));
        default: ;
      endcase
    end else if (cmd.start_mul) begin
      neg <= 1'b0;
      case (cmd.op)
        OP_PTERM: neg <= esq[31];
        OP_DTERM: neg <= dterm[31];
        OP_ITERM: neg <= (int_gain_dt != 0) ? esq[31] : integ[31];
        default: ;
      endcase
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          last <= smoothed;
          m <= reverse_mode ? sat32(-66'(measurement)) : measurement;
        end
        OP_ERR: dterm <= sat32(66'(smoothed) - 66'(last));
        OP_INTEG: begin
          if (int_gain_dt != 0) begin
            if (!(((pre > 34'(high_limit)) || (pre < 34'(low_limit))) &&
                  ((esq > 0 && pre > 34'(high_limit)) || (esq < 0 && pre < 34'(low_limit)))))
              integ <= pot[31:0];
          end else if (dec) begin
            integ <= itmp;
          end
        end
        OP_DRIVE: begin
          limit_hit <= (34'(pterm) + 34'(integ) - 34'(dterm) > 34'(high_limit)) ||
                       (34'(pterm) + 34'(integ) - 34'(dterm) < 34'(low_limit));
          if (dlt > 34'(SLEW_LIMIT)) prev <= sat32(66'(prev) + 66'(SLEW_LIMIT));
          else if (dlt < -34'(SLEW_LIMIT)) prev <= sat32(66'(prev) - 66'(SLEW_LIMIT));
          else prev <= raw[31:0];
        end
        default: ;
      endcase
    end
  end

  assign drive_value = prev;
endmodule

// ----- design/pfse_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfse_ctrl
// sequencer: walks the datapath through one control tick per input transfer
// ----------------------------------------------------------------------------
module pfse_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  output logic                 busy,
  input  logic                 out_free,
  output logic                 result_ready,
  output pfse_pkg::dp_cmd_t    cmd,
  input  pfse_pkg::dp_status_t status
);
  import pfse_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_ISSUE = 5'b00010, S_WAIT = 5'b00100, S_STEP = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;
  op_t    op, op_next;

  function automatic logic uses_mul(input op_t o);
    return o == OP_FILT_A || o == OP_FILT_B || o == OP_SQ || o == OP_PTERM ||
           o == OP_DTERM || o == OP_ITERM;
  endfunction

  always_comb begin
    state_next = state;
    op_next = op;
    case (state)
      // the load step runs at the input transfer edge itself
      S_IDLE:  if (in_fire) begin state_next = S_ISSUE; op_next = OP_FILT_A; end
      S_ISSUE: state_next = S_WAIT;
      S_WAIT:  if (status.mul_done) begin
        op_next = op_t'(op + 4'd1);
        state_next = uses_mul(op_t'(op + 4'd1)) ? S_ISSUE : S_STEP;
      end
      S_STEP: begin
        if (op == OP_DRIVE) state_next = S_DONE;
        else begin
          op_next = op_t'(op + 4'd1);
          state_next = uses_mul(op_t'(op + 4'd1)) ? S_ISSUE : S_STEP;
        end
      end
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= OP_LOAD;
    end else begin
      state <= state_next;
      op <= op_next;
    end
  end

  assign busy = state != S_IDLE;
  assign result_ready = state == S_DONE && out_free;
  assign cmd.start_mul = state == S_ISSUE;
  // load on the transfer edge; otherwise hold op steady in idle and done
  assign cmd.op = (state == S_IDLE) ? (in_fire ? OP_LOAD : OP_SQ) :
                  (state == S_DONE) ? OP_SQ : op;
endmodule

// ----- design/pid_filtered_squared_error_slew.sv -----
// ----------------------------------------------------------------------------
// pid_filtered_squared_error_slew
// q16.16 pid controller with filtered input, signed-squared error,
// clamping anti-windup and a slew-limited drive
// ----------------------------------------------------------------------------
//  channel   signals                                  direction
//  input     in_valid, in_ready, measurement          into block
//  output    out_valid, out_ready, drive_value,       out of block
//            limit_hit
//  config    cfg_we, cfg_index, cfg_data              into block
//
//  in each tick the measurement is loaded at the input transfer edge, then the
//  filter (two products), error, squared error, p, d and i products, integral
//  and drive steps run in that order; the six products share one 32x32 unit
//  (four 16x16 partial products), and the output reg is loaded once it is free
//  reset clears the filter, integral and drive state and the output valid flag, and sets config registers to defaults
//  the input waits while a tick runs or its result waits for the output reg
module pid_filtered_squared_error_slew (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] measurement,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] drive_value,
  output logic               limit_hit,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import pfse_pkg::*;

  logic [31:0] prop_gain, int_gain_dt, deriv_gain_dt;
  logic [16:0] filter_alpha;
  logic signed [31:0] target, low_limit, high_limit;
  logic reverse_mode, clear;
  logic busy, result_ready, out_free;
  logic in_fire;
  dp_cmd_t cmd;
  dp_status_t status;
  logic signed [31:0] dp_drive;
  logic dp_hit;

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;
  // output register free when empty or being drained this cycle
  assign out_free = !out_valid || out_ready;
  // a direction change clears the control state
  assign clear = cfg_we && cfg_index == REG_REVERSE && cfg_data[0] != reverse_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain <= 32'd65536;
      int_gain_dt <= '0;
      deriv_gain_dt <= '0;
      filter_alpha <= 17'd6554;
      target <= '0;
      low_limit <= '0;
      high_limit <= 32'sd16711680;
      reverse_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP:    prop_gain <= cfg_data;
        REG_INT:     int_gain_dt <= cfg_data;
        REG_DERIV:   deriv_gain_dt <= cfg_data;
        REG_ALPHA:   filter_alpha <= cfg_data[16:0];
        REG_TARGET:  target <= cfg_data;
        REG_LOW:     low_limit <= cfg_data;
        REG_HIGH:    high_limit <= cfg_data;
        REG_REVERSE: reverse_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pfse_ctrl u_ctrl (.clk(clk), .rst(rst), .in_fire(in_fire), .busy(busy),
    .out_free(out_free), .result_ready(result_ready), .cmd(cmd), .status(status));

  pfse_datapath u_dp (.clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .measurement(measurement), .prop_gain(prop_gain), .int_gain_dt(int_gain_dt),
    .deriv_gain_dt(deriv_gain_dt), .filter_alpha(filter_alpha), .target(target),
    .low_limit(low_limit), .high_limit(high_limit), .reverse_mode(reverse_mode),
    .clear(clear), .drive_value(dp_drive), .limit_hit(dp_hit));

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (result_ready) begin
        out_valid <= 1'b1;
        drive_value <= dp_drive;
        limit_hit <= dp_hit;
      end
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready) else $error("input taken during a tick");
  a_result_free: assert property (@(posedge clk) disable iff (rst)
    result_ready |-> (!out_valid || out_ready)) else $error("result overwrote output");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> busy) else $error("tick did not start");
endmodule
